// ===== rtl/sha_pkg.sv =====
// SHA-256 hasher package: types, constants and round functions
package sha_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = $clog2(QDEPTH);

	typedef enum logic [0:0] {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// word from front to back: one block of 16 words, finish flag
	typedef struct packed {
		logic [511:0] block;
		logic         finish;
	} blk_t;

	typedef enum logic [2:0] {
		FE_ABSORB,
		FE_PAD,
		FE_LEN,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_ROUND,
		BE_ADD,
		BE_EMIT
	} be_state_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage

// ===== rtl/sha_front.sv =====
// SHA-256 front end: collects bytes into blocks, pads and appends length
module sha_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [7:0]          in_byte,
	output logic                blk_valid,
	input  logic                blk_ready,
	output sha_pkg::blk_t       blk
);

	sha_pkg::fe_state_t state_q, state_d;
	logic [511:0] buf_q;
	logic [5:0]   fill_q;
	logic [63:0]  count_q;
	logic [63:0]  bits_q;
	logic         fin_q;
	logic [7:0]   wr_byte;
	logic         wr_en;
	logic         accept;

	assign accept = in_valid && in_ready;
	assign blk.block = buf_q;
	assign blk.finish = fin_q;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		blk_valid = 1'b0;
		wr_en = 1'b0;
		wr_byte = in_byte;
		unique case (state_q)
			sha_pkg::FE_ABSORB: begin
				in_ready = 1'b1;
				if (accept) begin
					wr_en = 1'b1;
					if (in_op == sha_pkg::OP_FINISH) begin
						wr_byte = sha_pkg::PAD_BYTE;
						state_d = (fill_q == 6'd63) ? sha_pkg::FE_PUSH
							: (fill_q == 6'd55) ? sha_pkg::FE_LEN : sha_pkg::FE_PAD;
					end else if (fill_q == 6'd63) begin
						state_d = sha_pkg::FE_PUSH;
					end
				end
			end
			sha_pkg::FE_PAD: begin
				wr_en = 1'b1;
				wr_byte = 8'h00;
				if (fill_q == 6'd63) begin
					state_d = sha_pkg::FE_PUSH;
				end else if (fill_q == sha_pkg::LEN_POS - 6'd1) begin
					state_d = sha_pkg::FE_LEN;
				end
			end
			sha_pkg::FE_LEN: begin
				wr_en = 1'b1;
				wr_byte = bits_q[8 * (7 - fill_q[2:0]) +: 8];
				if (fill_q == 6'd63) begin
					state_d = sha_pkg::FE_PUSH;
				end
			end
			sha_pkg::FE_PUSH: begin
				blk_valid = 1'b1;
				if (blk_ready) begin
					state_d = fin_q ? sha_pkg::FE_ABSORB
						: (bits_q[0] ? sha_pkg::FE_PAD : sha_pkg::FE_ABSORB);
				end
			end
			default: state_d = sha_pkg::FE_ABSORB;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::FE_ABSORB;
			fill_q <= '0;
			count_q <= '0;
			bits_q <= '0;
			fin_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (accept) begin
				if (in_op == sha_pkg::OP_FINISH) begin
					// bit 0 of the length is always zero; reuse it as a pad-pending mark
					bits_q <= {count_q[60:0], 2'b00, fill_q == 6'd63};
					count_q <= '0;
				end else begin
					count_q <= count_q + 64'd1;
				end
			end
			if (state_q == sha_pkg::FE_PAD && state_d == sha_pkg::FE_PUSH) begin
				bits_q[0] <= 1'b1;
			end
			if (state_q == sha_pkg::FE_LEN && state_d == sha_pkg::FE_PUSH) begin
				fin_q <= 1'b1;
			end
			if (state_q == sha_pkg::FE_PUSH && blk_ready) begin
				fin_q <= 1'b0;
				bits_q[0] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[8 * (63 - fill_q) +: 8] <= wr_byte;
		end
	end

endmodule

// ===== rtl/sha_queue.sv =====
// Block queue between front end and compression core
module sha_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  sha_pkg::blk_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output sha_pkg::blk_t rd_data
);

	sha_pkg::blk_t mem_q [sha_pkg::QDEPTH];
	logic [sha_pkg::QAW-1:0] wp_q, rp_q;
	logic [sha_pkg::QAW:0]   cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = cnt_q != sha_pkg::QAW'(0) + (sha_pkg::QAW+1)'(sha_pkg::QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (sha_pkg::QAW+1)'(do_wr) - (sha_pkg::QAW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/sha_core.sv =====
// SHA-256 compression core: one round per cycle, digest output register
module sha_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          blk_valid,
	output logic          blk_ready,
	input  sha_pkg::blk_t blk,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_word,
	output logic [2:0]    out_index,
	output logic          out_last
);

	sha_pkg::be_state_t state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        fin_q;
	logic [31:0] t1, t2, wn;

	assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha_pkg::ROUND_K[rnd_q] + w_q[0];
	assign t2 = sha_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
		^ (v_q[1] & v_q[2]));
	assign wn = w_q[0] + sha_pkg::sig0(w_q[1]) + w_q[9] + sha_pkg::sig1(w_q[14]);

	assign out_valid = state_q == sha_pkg::BE_EMIT;
	assign out_word = h_q[idx_q];
	assign out_index = idx_q;
	assign out_last = idx_q == 3'd7;

	always_comb begin
		state_d = state_q;
		blk_ready = 1'b0;
		unique case (state_q)
			sha_pkg::BE_IDLE: begin
				blk_ready = 1'b1;
				if (blk_valid) begin
					state_d = sha_pkg::BE_ROUND;
				end
			end
			sha_pkg::BE_ROUND: if (rnd_q == 6'd63) begin
				state_d = sha_pkg::BE_ADD;
			end
			sha_pkg::BE_ADD: state_d = fin_q ? sha_pkg::BE_EMIT : sha_pkg::BE_IDLE;
			sha_pkg::BE_EMIT: if (out_ready && idx_q == 3'd7) begin
				state_d = sha_pkg::BE_IDLE;
			end
			default: state_d = sha_pkg::BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::BE_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::INIT_H[i];
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sha_pkg::BE_IDLE: begin
					rnd_q <= '0;
					idx_q <= '0;
					if (blk_valid) begin
						fin_q <= blk.finish;
					end
				end
				sha_pkg::BE_ROUND: rnd_q <= rnd_q + 6'd1;
				sha_pkg::BE_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
				sha_pkg::BE_EMIT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= sha_pkg::INIT_H[i];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sha_pkg::BE_IDLE && blk_valid) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk.block[32 * (15 - i) +: 32];
			end
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == sha_pkg::BE_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wn;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher top level
//
// channel  dir  fields (tdata / tuser)
// s_axis   in   tdata: data_byte[7:0]; tuser: op
// m_axis   out  tdata: digest_word[31:0]; tuser: word_index[2:0], last_word[3]; tlast
//
// Absorb writes each byte into the block buffer and stops taking bytes while a
// full 64-byte block is handed to the queue. The core runs one round per cycle,
// then adds into the hash; a long message is paced by the core once the queue fills.
// Finish pads at one byte per cycle, then the core emits eight words.
// A four-block queue lets the front keep taking bytes while the core runs.
// Reset is asynchronous and restores the initial hash; no clearing pass.
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // digest_word[31:0]
	output logic [3:0]  m_axis_tuser,  // word_index[2:0], last_word[3]
	output logic        m_axis_tlast
);

	sha_pkg::blk_t f_blk, c_blk;
	logic f_valid, f_ready, c_valid, c_ready;
	logic [2:0] idx;
	logic last;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(s_axis_tuser), .in_byte(s_axis_tdata),
		.blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
	);

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
		.rd_valid(c_valid), .rd_ready(c_ready), .rd_data(c_blk)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.blk_valid(c_valid), .blk_ready(c_ready), .blk(c_blk),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(m_axis_tdata), .out_index(idx), .out_last(last)
	);

	assign m_axis_tuser = {last, idx};
	assign m_axis_tlast = last;

endmodule

// ===== rtl/sha_checker.sv =====
// Port-level checker for the SHA-256 hasher, bound to the top level
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:0] == 3'd7)))
		else $error("tlast does not match word index");

	a_last_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[3] == m_axis_tlast))
		else $error("last_word differs from tlast");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1))
		else $error("digest words not contiguous");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled word changed");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);
